>>> rtl/encoder_pi_speed_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// encoder pi speed controller assertion macros
// Shared property forms; each use relies on clk and rst_n in the module scope.
// ----------------------------------------------------------------------------
`ifndef ENCODER_PI_SPEED_CONTROLLER_UNIT_ASSERT_SVH
`define ENCODER_PI_SPEED_CONTROLLER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define EPSC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define EPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/epsc_pkg.sv
// ----------------------------------------------------------------------------
// epsc_pkg
// Types, codes and constants of the encoder pi speed controller.
// ----------------------------------------------------------------------------
package epsc_pkg;

    // field widths
    localparam int COUNT_W  = 32;
    localparam int TARGET_W = 16;
    localparam int DRIVE_W  = 17;
    localparam int RATE_W   = 26;
    localparam int GAIN_W   = 16;
    localparam int PPS_W    = 10;
    localparam int MAG_W    = 16;
    localparam int TMAG_W   = 17;
    localparam int ERR_W    = 28;
    localparam int MUL_A_W  = 18;
    localparam int PROD_W   = MUL_A_W + ERR_W;
    localparam int INTEG_W  = 32;
    localparam int SUM_W    = PROD_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reset values of the registers
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 16'd256;
    localparam logic [GAIN_W-1:0] INTEGRAL_GAIN_RST = 16'd0;
    localparam logic [PPS_W-1:0]  PPS_RST           = 10'd20;

    // saturation limits
    localparam logic [MAG_W-1:0] DELTA_MAX = 16'hFFFF;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 17'sd65535;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -17'sd65535;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN     = 2'd0,
        CFG_INTEGRAL_GAIN = 2'd1,
        CFG_PPS           = 2'd2
    } epsc_cfg_idx_t;

    // input item
    typedef struct packed {
        logic signed [COUNT_W-1:0]  encoder_count;
        logic signed [TARGET_W-1:0] speed_target;
    } epsc_in_t;

    // result item
    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_level;
        logic                      forward;
        logic [RATE_W-1:0]         measured_rate;
    } epsc_out_t;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MUL_RATE,
        MUL_PROP,
        MUL_INT
    } epsc_mul_sel_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_RATE_MUL,
        ST_ERROR,
        ST_PROP_MUL,
        ST_INT_MUL,
        ST_INT_UPD,
        ST_SUM,
        ST_DONE
    } epsc_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic          load_in;
        logic          mag_en;
        logic          mul_en;
        epsc_mul_sel_t mul_sel;
        logic          err_en;
        logic          pterm_en;
        logic          integ_en;
        logic          sum_en;
        logic          out_load;
    } epsc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;
    } epsc_status_t;

endpackage

>>> rtl/epsc_ctrl.sv
// ----------------------------------------------------------------------------
// epsc_ctrl
// Sequencer that steps one control tick through the shared datapath.
// ----------------------------------------------------------------------------
`include "encoder_pi_speed_controller_unit_assert.svh"

module epsc_ctrl
    import epsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  epsc_status_t status,
    output epsc_cmd_t    cmd
);

    epsc_state_t state_reg;
    epsc_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:    state_next = ST_RATE_MUL;
            ST_RATE_MUL: state_next = ST_ERROR;
            ST_ERROR:    state_next = ST_PROP_MUL;
            ST_PROP_MUL: state_next = ST_INT_MUL;
            ST_INT_MUL:  state_next = ST_INT_UPD;
            ST_INT_UPD:  state_next = ST_SUM;
            ST_SUM:      state_next = ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        cmd.mul_sel = MUL_RATE;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            ST_DELTA:
            begin
                cmd.mag_en = 1'b1;
            end
            ST_RATE_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RATE;
            end
            ST_ERROR:
            begin
                cmd.err_en = 1'b1;
            end
            ST_PROP_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROP;
            end
            ST_INT_MUL:
            begin
                cmd.pterm_en = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_INT;
            end
            ST_INT_UPD:
            begin
                cmd.integ_en = 1'b1;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // a transfer in starts the sequence
    `EPSC_ASSERT_NEXT(a_accept_starts, (state_reg == ST_IDLE) && in_valid,
        state_reg == ST_DELTA, "accepted tick did not start the sequence")

    // a finished result waits while the output register is occupied
    `EPSC_ASSERT_NEXT(a_done_waits, (state_reg == ST_DONE) && !status.out_free,
        state_reg == ST_DONE, "result left before output register was free")

endmodule

>>> rtl/epsc_datapath.sv
// ----------------------------------------------------------------------------
// epsc_datapath
// Configuration, state, shared multiplier and output register of the
// speed controller.
// ----------------------------------------------------------------------------
`include "encoder_pi_speed_controller_unit_assert.svh"

module epsc_datapath
    import epsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  epsc_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output epsc_out_t             out_data,
    input  epsc_cmd_t             cmd,
    output epsc_status_t          status
);

    logic [GAIN_W-1:0]  prop_gain_reg;
    logic [GAIN_W-1:0]  integral_gain_reg;
    logic [PPS_W-1:0]   pps_reg;

    logic [COUNT_W-1:0] prev_count_reg;
    logic [INTEG_W-1:0] integ_reg;
    logic [INTEG_W-1:0] integ_next;

    logic [COUNT_W-1:0]         diff_reg;
    logic signed [TARGET_W-1:0] target_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic [MAG_W-1:0]           mag_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic [RATE_W-1:0]          rate_reg;
    logic signed [ERR_W-1:0]    error_reg;
    logic signed [ERR_W-1:0]    error_next;
    logic signed [PROD_W-1:0]   pterm_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    epsc_out_t                  out_data_reg;
    epsc_out_t                  out_data_next;

    logic [COUNT_W-1:0]         diff_abs;
    logic [TMAG_W-1:0]          tmag;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [ERR_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   inew;
    logic signed [SUM_W-1:0]    sum_adj;
    logic signed [SUM_W-9:0]    quot;
    logic signed [DRIVE_W-1:0]  drive;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= PROP_GAIN_RST;
            integral_gain_reg <= INTEGRAL_GAIN_RST;
            pps_reg           <= PPS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                CFG_INTEGRAL_GAIN: integral_gain_reg <= cfg_data;
                CFG_PPS:           pps_reg           <= cfg_data[PPS_W-1:0];
                default:           ;
            endcase
        end
    end

    // controller state: previous count and integrator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_count_reg <= '0;
            integ_reg      <= '0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                prev_count_reg <= in_data.encoder_count;
            end
            if (cmd.integ_en)
            begin
                integ_reg <= integ_next;
            end
        end
    end

    // saturated magnitude of the wrapped pulse delta
    always_comb
    begin
        diff_abs = diff_reg[COUNT_W-1] ? (COUNT_W'(0) - diff_reg) : diff_reg;
        if (diff_abs[COUNT_W-1:MAG_W] != '0)
        begin
            mag_next = DELTA_MAX;
        end
        else
        begin
            mag_next = diff_abs[MAG_W-1:0];
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_RATE:
            begin
                mul_a = $signed({2'b00, mag_reg});
                mul_b = $signed({{(ERR_W-PPS_W){1'b0}}, pps_reg});
            end
            MUL_PROP:
            begin
                mul_a = $signed({2'b00, prop_gain_reg});
                mul_b = error_reg;
            end
            MUL_INT:
            begin
                mul_a = $signed({2'b00, integral_gain_reg});
                mul_b = error_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // error: target magnitude minus measured rate
    always_comb
    begin
        tmag = target_reg[TARGET_W-1]
             ? (TMAG_W'(0) - {target_reg[TARGET_W-1], target_reg})
             : {1'b0, target_reg};
        error_next = $signed({{(ERR_W-TMAG_W){1'b0}}, tmag})
                   - $signed({{(ERR_W-RATE_W){1'b0}}, prod_reg[RATE_W-1:0]});
    end

    // integrator update, clamped at zero and at full scale
    always_comb
    begin
        inew = $signed({{(PROD_W-INTEG_W){1'b0}}, integ_reg}) + prod_reg;
        if (inew[PROD_W-1])
        begin
            integ_next = '0;
        end
        else if (inew[PROD_W-2:INTEG_W] != '0)
        begin
            integ_next = '1;
        end
        else
        begin
            integ_next = inew[INTEG_W-1:0];
        end
    end

    // proportional term plus integrator
    assign sum_next = $signed({pterm_reg[PROD_W-1], pterm_reg})
                    + $signed({{(SUM_W-INTEG_W){1'b0}}, integ_reg});

    // truncate toward zero, saturate, shut down at rest
    always_comb
    begin
        sum_adj = sum_reg + (sum_reg[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
        quot    = sum_adj[SUM_W-1:8];
        if (quot > $signed((SUM_W-8)'(DRIVE_MAX)))
        begin
            drive = DRIVE_MAX;
        end
        else if (quot < $signed({{(SUM_W-8-DRIVE_W){1'b1}}, DRIVE_MIN}))
        begin
            drive = DRIVE_MIN;
        end
        else
        begin
            drive = quot[DRIVE_W-1:0];
        end
        if ((target_reg == '0) && (integ_reg == '0))
        begin
            drive = '0;
        end
        out_data_next.drive_level   = drive;
        out_data_next.forward       = ~target_reg[TARGET_W-1];
        out_data_next.measured_rate = rate_reg;
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            diff_reg   <= in_data.encoder_count - prev_count_reg;
            target_reg <= in_data.speed_target;
        end
        if (cmd.mag_en)
        begin
            mag_reg <= mag_next;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.err_en)
        begin
            rate_reg  <= prod_reg[RATE_W-1:0];
            error_reg <= error_next;
        end
        if (cmd.pterm_en)
        begin
            pterm_reg <= prod_reg;
        end
        if (cmd.sum_en)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // output register valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    // integrator only moves in its update step
    `EPSC_ASSERT_NEXT(a_integ_hold, !cmd.integ_en, $stable(integ_reg),
        "integrator changed outside its update step")

    // drive level stays inside its saturation range
    `EPSC_ASSERT_IMPLIES(a_drive_range, out_valid_reg,
        out_data_reg.drive_level != -17'sd65536, "drive level out of range")

    // zero target with empty integrator gives zero drive
    `EPSC_ASSERT_NEXT(a_shutdown,
        cmd.out_load && (target_reg == '0) && (integ_reg == '0),
        out_data_reg.drive_level == '0, "shutdown did not zero the drive")

endmodule

>>> rtl/encoder_pi_speed_controller_unit.sv
// ----------------------------------------------------------------------------
// encoder_pi_speed_controller_unit
// Encoder-fed PI speed controller: one control tick in, one drive result out.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data   (epsc_in_t)
//   out      output     out_valid/out_stall  out_data  (epsc_out_t)
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// A tick is handled in sequence from transfer in to result loaded; one shared
// 18x28 multiplier is used three times in sequence. A new tick is taken only
// once the previous result has been loaded into the output register.
// Reset clears the previous count and the integrator and loads the default
// gains and tick rate; no clearing pass is needed.
// A stalled output holds its result; the next tick still enters and runs,
// and waits in its last step until the output register frees up.
// ----------------------------------------------------------------------------
module encoder_pi_speed_controller_unit
    import epsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  epsc_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output epsc_out_t             out_data
);

    epsc_cmd_t    cmd;
    epsc_status_t status;

    // sequencer
    epsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    epsc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
